/* src/fwb_pkg.sv */
// ---------------------------------------------------------------------------
// fwb_pkg
// shared types and constants of the bilinear flow warp unit
// ---------------------------------------------------------------------------
package fwb_pkg;

  localparam int MAX_WIDTH_DEF      = 256;
  localparam int MAX_HEIGHT_DEF     = 256;
  localparam int FLOW_FRAC_BITS_DEF = 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_WARP = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        pix_red;
    logic [7:0]        pix_green;
    logic [7:0]        pix_blue;
    logic signed [15:0] flow_dx;
    logic signed [15:0] flow_dy;
  } fwb_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } fwb_out_t;

endpackage

/* src/fwb_ram.sv */
// ---------------------------------------------------------------------------
// fwb_ram
// single-port-write, single-port-read ram with registered read data
// ---------------------------------------------------------------------------
module fwb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/flow_warp_bilinear_unit.sv */
// ---------------------------------------------------------------------------
// flow_warp_bilinear_unit
// bilinear frame remap by a flow field, clamped to the frame edge
// ---------------------------------------------------------------------------
// Usage: a load beat (cmd=0) writes the next source pixel in raster order
// into the frame store. A warp beat (cmd=1) carries a Q flow vector for the
// next output pixel in raster order; the unit samples the stored frame at
// (col+dx, row+dy) and returns one output beat. Loads return nothing.
// The store is one ram addressed row*width+col; the four neighbors of a
// sample are read one per cycle, so a warp holds the input while in flight
// and reads never meet a write.
// A warp beat passes through the base address, four ram reads, the
// vertical blend and the horizontal blend into the output register.
// Loads are accepted back to back; a warp keeps in_stall high until its
// result enters the output register, so no new beat is taken in flight.
// Reset clears counters and output valid and sets both sizes to 256; the
// store is not cleared, and in_stall is high during reset. When the
// receiver stalls, a finished result waits for the output register and
// in_stall stays high so no beat is lost.
// Configuration writes are taken at any time (ready is always high) and
// belong where no warp is in flight.
// ---------------------------------------------------------------------------
module flow_warp_bilinear_unit
  import fwb_pkg::*;
#(
  parameter int MAX_WIDTH      = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = MAX_HEIGHT_DEF,
  parameter int FLOW_FRAC_BITS = FLOW_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fwb_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fwb_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]           cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int AW  = CW + RW;
  localparam int F   = FLOW_FRAC_BITS;
  localparam int PW  = 32;  // wide enough for coordinates and flow
  localparam logic [PW-1:0] ONE = PW'(1) << F;
  localparam logic [AW:0] STORE_DEPTH = (AW+1)'(MAX_WIDTH) * (AW+1)'(MAX_HEIGHT);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_VERT = 3'd3;
  localparam logic [2:0] ST_HORZ = 3'd4;

  localparam logic [2:0] RD_DONE = 3'd4;

  // configuration
  logic [8:0] image_width, image_height;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [12:0] w, h;
  assign w = (image_width < 9'd2) ? 13'd2 :
             (13'(image_width) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(image_width);
  assign h = (image_height < 9'd2) ? 13'd2 :
             (13'(image_height) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(image_height);

  logic [2:0] state;
  logic       acc;
  logic       out_free;
  assign in_stall = rst || (state != ST_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // load side: linear raster address
  logic [AW:0] load_address;
  logic [AW:0] wh;
  logic        ld;
  assign wh = (AW+1)'(w) * (AW+1)'(h);
  assign ld = acc && in_data.cmd == CMD_LOAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_address <= '0;
    end else if (ld) begin
      if (load_address + 1'b1 >= wh) load_address <= '0;
      else load_address <= load_address + 1'b1;
    end
  end

  // query counters
  logic [CW-1:0] query_col;
  logic [RW-1:0] query_row;
  logic          wp;
  logic          last_px;
  assign wp = acc && in_data.cmd == CMD_WARP;
  assign last_px = (13'(query_col) + 13'd1 >= w) && (13'(query_row) + 13'd1 >= h);

  always_ff @(posedge clk) begin
    if (rst) begin
      query_col <= '0;
      query_row <= '0;
    end else if (wp) begin
      if (13'(query_col) + 13'd1 >= w) begin
        query_col <= '0;
        query_row <= (13'(query_row) + 13'd1 >= h) ? '0 : query_row + 1'b1;
      end else begin
        query_col <= query_col + 1'b1;
      end
    end
  end

  // coordinate split
  function automatic logic [PW+12:0] split(input logic [RW+CW-1:0] pos_i,
                                           input logic signed [15:0] d,
                                           input logic [12:0] size);
    logic signed [PW-1:0] pos;
    logic [PW-1:0] b, f;
    begin
      pos = $signed(PW'(pos_i) << F) + PW'(d);
      if (pos < 0) begin
        b = '0;
        f = '0;
      end else begin
        b = PW'(pos) >> F;
        if (b > PW'(size) - PW'(2)) b = PW'(size) - PW'(2);
        f = PW'(pos) - (b << F);
        if (f > ONE) f = ONE;
      end
      split = {b[12:0], f};
    end
  endfunction

  // base cell and weights, taken with the warp beat
  logic [12:0]    bx, by;
  logic [F:0]     fx, fy;
  logic           px_end;
  logic [PW+12:0] sx, sy;
  assign sx = split((RW+CW)'(query_col), in_data.flow_dx, w);
  assign sy = split((RW+CW)'(query_row), in_data.flow_dy, h);

  always_ff @(posedge clk) begin
    if (wp) begin
      bx     <= sx[PW+12:PW];
      fx     <= sx[F:0];
      by     <= sy[PW+12:PW];
      fy     <= sy[F:0];
      px_end <= last_px;
    end
  end

  // sequencer: address, four reads, two blend steps
  logic [2:0] rd_cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (wp) state <= ST_ADDR;
        end
        ST_ADDR: begin
          state  <= ST_READ;
          rd_cnt <= '0;
        end
        ST_READ: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == RD_DONE) state <= ST_VERT;
        end
        ST_VERT: begin
          state <= ST_HORZ;
        end
        ST_HORZ: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  logic [AW:0] base;
  always_ff @(posedge clk) begin
    if (state == ST_ADDR) base <= (AW+1)'(by) * (AW+1)'(w) + (AW+1)'(bx);
  end

  // read order: base, below (+w), right (+1), diagonal (+w+1)
  logic [AW:0]    offs;
  logic [AW-1:0]  rd_addr;
  logic [23:0]    rd_data;
  logic           wr_en;
  logic [23:0]    wr_data;
  assign offs    = (rd_cnt[0] ? (AW+1)'(w) : '0) + (AW+1)'(rd_cnt[1]);
  assign rd_addr = AW'(base + offs);
  assign wr_en   = ld && (load_address < STORE_DEPTH);
  assign wr_data = {in_data.pix_red, in_data.pix_green, in_data.pix_blue};

  fwb_ram #(.WIDTH(24), .DEPTH(1 << AW)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(load_address[AW-1:0]), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // the ram registers its read data, so read k shows up in the cycle after its address
  logic [23:0] pa, pb, pc, pd;
  always_ff @(posedge clk) begin
    if (state == ST_READ && rd_cnt != 3'd0) {pa, pb, pc, pd} <= {pb, pc, pd, rd_data};
  end

  // vertical blend
  localparam int VW = 8 + F + 1;
  logic [VW-1:0] s3_l [3], s3_r [3];
  logic [F:0]    fy0;
  assign fy0 = (F+1)'(ONE) - fy;
  always_ff @(posedge clk) begin
    if (state == ST_VERT) begin
      for (int k = 0; k < 3; k++) begin
        s3_l[k] <= VW'(pa[16-8*k +: 8]) * VW'(fy0) + VW'(pb[16-8*k +: 8]) * VW'(fy);
        s3_r[k] <= VW'(pc[16-8*k +: 8]) * VW'(fy0) + VW'(pd[16-8*k +: 8]) * VW'(fy);
      end
    end
  end

  // horizontal blend into output register
  localparam int HW = VW + F + 1;
  logic [F:0]    fx0;
  logic [HW-1:0] hs [3];
  assign fx0 = (F+1)'(ONE) - fx;
  always_comb begin
    for (int k = 0; k < 3; k++)
      hs[k] = HW'(s3_l[k]) * HW'(fx0) + HW'(s3_r[k]) * HW'(fx);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_HORZ && out_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (state == ST_HORZ && out_free) begin
      out_data.out_red   <= hs[0][2*F +: 8];
      out_data.out_green <= hs[1][2*F +: 8];
      out_data.out_blue  <= hs[2][2*F +: 8];
      out_data.frame_end <= px_end;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    ld |=> state == ST_IDLE)
    else $error("load started a warp");
  a_wp_starts: assert property (@(posedge clk) disable iff (rst)
    wp |=> state == ST_ADDR)
    else $error("warp not started");
  a_base_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ADDR |-> (bx + 13'd2 <= w) && (by + 13'd2 <= h))
    else $error("base cell out of range");
  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == ST_HORZ && !out_free |=> state == ST_HORZ)
    else $error("result dropped under stall");

endmodule
